// ----- rtl/nsrp_pkg.sv -----
// Package for the number sequence range parser.
// Holds the transaction types, register indexes and character constants.
// Used by every module in the rtl folder; depends on nothing.
package nsrp_pkg;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND = 2'd1;

	localparam logic [VALUE_W-1:0] LOWER_BOUND_RESET = '0;
	localparam logic [VALUE_W-1:0] UPPER_BOUND_RESET = '1;

	localparam logic [7:0] CHAR_COMMA     = 8'h2C;
	localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
	localparam logic [7:0] CHAR_SPACE     = 8'h20;
	localparam logic [7:0] CHAR_TAB       = 8'h09;
	localparam logic [7:0] CHAR_LF        = 8'h0A;
	localparam logic [7:0] CHAR_VT        = 8'h0B;
	localparam logic [7:0] CHAR_FF        = 8'h0C;
	localparam logic [7:0] CHAR_CR        = 8'h0D;
	localparam logic [7:0] CHAR_DASH      = 8'h2D;
	localparam logic [7:0] CHAR_ZERO      = 8'h30;
	localparam logic [7:0] CHAR_NINE      = 8'h39;

	typedef enum logic [1:0] {
		CLS_DELIM,
		CLS_DIGIT,
		CLS_DASH,
		CLS_OTHER
	} char_class_t;

	typedef struct packed {
		logic [7:0] character;
		logic       end_marker;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] range_first;
		logic [VALUE_W-1:0] range_end;
		logic               has_range;
		logic               sequence_done;
		logic               parse_failed;
	} out_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] lower_bound;
		logic [VALUE_W-1:0] upper_bound;
	} cfg_regs_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cls;
		if (c inside {CHAR_COMMA, CHAR_SEMICOLON, CHAR_SPACE, CHAR_TAB,
				CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR}) begin
			cls = CLS_DELIM;
		end else if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
			cls = CLS_DIGIT;
		end else if (c == CHAR_DASH) begin
			cls = CLS_DASH;
		end else begin
			cls = CLS_OTHER;
		end
		return cls;
	endfunction

endpackage

// ----- rtl/number_sequence_range_parser.sv -----
// Top level of the number sequence range parser.
// Instantiates nsrp_cfg, nsrp_core and nsrp_obuf; depends on nsrp_pkg.
//
// The block parses a text of decimal numbers and ranges such as "3,5-9" or "-4", one
// character per transaction, closed by a transaction with end_marker set. Each kept piece
// leaves as a half-open interval [range_first, range_end) clamped to the lower_bound and
// upper_bound registers; the end marker always produces one final transaction with
// sequence_done set and parse_failed reporting any unknown character. The block takes one
// character per cycle while in_stall is low: a character is registered on acceptance and
// handled by the parser core once the output buffer has room, and its result, if any, is
// registered in the output buffer. A two-entry output buffer lets the input keep flowing
// while a result waits; in_stall rises only once both entries are full. Write the bound
// registers only while no transaction is in flight.
module number_sequence_range_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  nsrp_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output nsrp_pkg::out_item_t            out_item,
	input  logic                           cfg_we,
	input  logic [nsrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nsrp_pkg::VALUE_W-1:0]   cfg_data
);

	nsrp_pkg::cfg_regs_t cfg;
	logic                in_valid_s1;
	nsrp_pkg::in_item_t  in_item_s1;
	logic                can_push;
	logic                step;
	logic                res_valid;
	nsrp_pkg::out_item_t res;

	assign step     = in_valid_s1 && can_push;
	assign in_stall = in_valid_s1 && !can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_item_s1 <= in_item;
		end
	end

	nsrp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (cfg)
	);

	nsrp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (in_item_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	nsrp_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_item (res),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ----- rtl/nsrp_cfg.sv -----
// Configuration registers of the number sequence range parser.
// Holds lower_bound and upper_bound; depends on nsrp_pkg.
module nsrp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [nsrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nsrp_pkg::VALUE_W-1:0]    cfg_data,
	output nsrp_pkg::cfg_regs_t             regs
);

	nsrp_pkg::cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.lower_bound <= nsrp_pkg::LOWER_BOUND_RESET;
			regs_q.upper_bound <= nsrp_pkg::UPPER_BOUND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				nsrp_pkg::REG_LOWER_BOUND: regs_q.lower_bound <= cfg_data;
				nsrp_pkg::REG_UPPER_BOUND: regs_q.upper_bound <= cfg_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ----- rtl/nsrp_core.sv -----
// Parser core: number accumulation, range tracking and interval output.
// Processes one character per step; depends on nsrp_pkg.
module nsrp_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  nsrp_pkg::in_item_t  item,
	input  nsrp_pkg::cfg_regs_t cfg,
	output logic                res_valid,
	output nsrp_pkg::out_item_t res
);

	logic                         digits_seen_q;
	logic [nsrp_pkg::VALUE_W-1:0] acc_q;
	logic                         overflowed_q;
	logic                         range_open_q;
	logic [nsrp_pkg::VALUE_W-1:0] range_begin_q;
	logic                         error_seen_q;

	logic                         digits_seen_d;
	logic [nsrp_pkg::VALUE_W-1:0] acc_d;
	logic                         overflowed_d;
	logic                         range_open_d;
	logic [nsrp_pkg::VALUE_W-1:0] range_begin_d;
	logic                         error_seen_d;

	nsrp_pkg::char_class_t        cls;
	logic [nsrp_pkg::VALUE_W+3:0] product;
	logic [nsrp_pkg::VALUE_W-1:0] stop;
	logic                         acc_in_bounds;
	logic                         close_give;
	logic [nsrp_pkg::VALUE_W-1:0] close_first;
	logic [nsrp_pkg::VALUE_W-1:0] close_end;

	assign cls = nsrp_pkg::classify(item.character);

	// acc * 10 + digit, four bits wider so that any carry shows as overflow.
	// The ASCII digits have their value in the low nibble.
	assign product = ({4'b0000, acc_q} << 3) + ({4'b0000, acc_q} << 1)
		+ {{nsrp_pkg::VALUE_W{1'b0}}, item.character[3:0]};

	assign acc_in_bounds = (acc_q < cfg.upper_bound);
	assign stop = (digits_seen_q && acc_in_bounds) ? acc_q + 1'b1 : cfg.upper_bound;

	// Closing the current piece; an overflowed piece is dropped silently.
	always_comb begin
		close_give  = 1'b0;
		close_first = '0;
		close_end   = '0;
		if (overflowed_q) begin
			close_give = 1'b0;
		end else if (range_open_q) begin
			if (stop > range_begin_q) begin
				close_give  = 1'b1;
				close_first = range_begin_q;
				close_end   = stop;
			end
		end else if (digits_seen_q && acc_q >= cfg.lower_bound && acc_in_bounds) begin
			close_give  = 1'b1;
			close_first = acc_q;
			close_end   = acc_q + 1'b1;
		end
	end

	always_comb begin
		digits_seen_d = digits_seen_q;
		acc_d         = acc_q;
		overflowed_d  = overflowed_q;
		range_open_d  = range_open_q;
		range_begin_d = range_begin_q;
		error_seen_d  = error_seen_q;
		res_valid     = 1'b0;
		res           = '0;
		if (step) begin
			if (item.end_marker) begin
				res_valid         = 1'b1;
				res.sequence_done = 1'b1;
				res.parse_failed  = error_seen_q;
				if (!error_seen_q && close_give) begin
					res.has_range   = 1'b1;
					res.range_first = close_first;
					res.range_end   = close_end;
				end
				digits_seen_d = 1'b0;
				acc_d         = '0;
				overflowed_d  = 1'b0;
				range_open_d  = 1'b0;
				range_begin_d = '0;
				error_seen_d  = 1'b0;
			end else if (!error_seen_q) begin
				case (cls)
					nsrp_pkg::CLS_DELIM: begin
						res_valid       = close_give;
						res.has_range   = close_give;
						res.range_first = close_first;
						res.range_end   = close_end;
						if (overflowed_q) begin
							overflowed_d = 1'b0;
						end else begin
							range_open_d = 1'b0;
						end
						digits_seen_d = 1'b0;
						acc_d         = '0;
					end
					nsrp_pkg::CLS_DIGIT: begin
						digits_seen_d = 1'b1;
						acc_d         = product[nsrp_pkg::VALUE_W-1:0];
						if (product[nsrp_pkg::VALUE_W+3:nsrp_pkg::VALUE_W] != 4'b0000) begin
							overflowed_d = 1'b1;
						end
					end
					nsrp_pkg::CLS_DASH: begin
						range_begin_d = (digits_seen_q && acc_q >= cfg.lower_bound)
							? acc_q : cfg.lower_bound;
						range_open_d  = 1'b1;
						digits_seen_d = 1'b0;
						acc_d         = '0;
					end
					default: begin
						error_seen_d = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_seen_q <= 1'b0;
			acc_q         <= '0;
			overflowed_q  <= 1'b0;
			range_open_q  <= 1'b0;
			range_begin_q <= '0;
			error_seen_q  <= 1'b0;
		end else begin
			digits_seen_q <= digits_seen_d;
			acc_q         <= acc_d;
			overflowed_q  <= overflowed_d;
			range_open_q  <= range_open_d;
			range_begin_q <= range_begin_d;
			error_seen_q  <= error_seen_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_end_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.end_marker |=>
			!error_seen_q && !range_open_q && !digits_seen_q && !overflowed_q)
		else $error("state not cleared after end marker");

	a_mid_result_has_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.sequence_done |-> res.has_range && !res.parse_failed)
		else $error("delimiter result without an interval");

	a_interval_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.has_range |-> res.range_end > res.range_first)
		else $error("empty interval reported");

	a_failed_no_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.parse_failed |-> !res.has_range && res.sequence_done)
		else $error("interval reported on a failed parse");
`endif

endmodule

// ----- rtl/nsrp_obuf.sv -----
// Two-entry output buffer (result register plus skid register).
// Decouples the result channel stall from the parser; depends on nsrp_pkg.
module nsrp_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  nsrp_pkg::out_item_t push_item,
	output logic                can_push,
	output logic                out_valid,
	input  logic                out_stall,
	output nsrp_pkg::out_item_t out_item
);

	logic                main_valid_q;
	logic                skid_valid_q;
	nsrp_pkg::out_item_t main_q;
	nsrp_pkg::out_item_t skid_q;
	logic                pop;

	assign pop       = main_valid_q && !out_stall;
	// A push is only allowed while the skid register is empty, so order is kept.
	assign can_push  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_item  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (!main_valid_q || pop) begin
				main_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			main_valid_q <= skid_valid_q;
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!main_valid_q || pop) begin
				main_q <= push_item;
			end else begin
				skid_q <= push_item;
			end
		end else if (pop && skid_valid_q) begin
			main_q <= skid_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_skid_implies_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held without a result entry");
`endif

endmodule

// ----- tb/sv/tb_number_sequence_range_parser.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for number_sequence_range_parser: feeds decimal texts of numbers
// and ranges one character per transaction and checks every interval the block gives.
// Depends on nsrp_pkg and the RTL of the block; needs nothing else.
module tb_number_sequence_range_parser;
	import nsrp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int HOLD_AFTER_RESULTS = 20;
	localparam int HOLD_CYCLES        = 400;
	localparam int SETTLE_CYCLES      = 8;
	localparam int CYCLE_LIMIT        = 200_000;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_item;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VALUE_W-1:0]   cfg_data  = '0;

	// Parser state as the block should hold it, with its copy of the bound registers.
	logic [VALUE_W-1:0] bound_lo = LOWER_BOUND_RESET;
	logic [VALUE_W-1:0] bound_hi = UPPER_BOUND_RESET;
	bit                 have_digits;
	logic [VALUE_W-1:0] num_value;
	bit                 num_overflow;
	bit                 span_open;
	logic [VALUE_W-1:0] span_start;
	bit                 bad_char;

	in_item_t    text_queue[$];
	out_item_t   expected_ranges[$];
	int          send_idle_pct = 6;
	int          recv_idle_pct = 45;
	int          items_made;
	bit          text_broken;
	int unsigned mismatches;
	int          results_seen;
	int          hold_left;
	bit          hold_done;
	int          cycle_count;

	number_sequence_range_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic char_class_t char_kind(input logic [7:0] c);
		char_class_t k;
		case (c)
			CHAR_COMMA, CHAR_SEMICOLON, CHAR_SPACE, CHAR_TAB,
			CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR: k = CLS_DELIM;
			CHAR_DASH: k = CLS_DASH;
			default: k = (c >= CHAR_ZERO && c <= CHAR_NINE) ? CLS_DIGIT : CLS_OTHER;
		endcase
		return k;
	endfunction

	function automatic void reset_parse();
		have_digits  = 1'b0;
		num_value    = '0;
		num_overflow = 1'b0;
		span_open    = 1'b0;
		span_start   = '0;
		bad_char     = 1'b0;
	endfunction

	// Ends the current piece; returns 1 when it yields a non-empty interval.
	function automatic bit finish_piece(output logic [VALUE_W-1:0] lo_val,
			output logic [VALUE_W-1:0] hi_val);
		bit                 give;
		logic [VALUE_W-1:0] top;
		give   = 1'b0;
		lo_val = '0;
		hi_val = '0;
		if (num_overflow) begin
			// An overflowed piece is dropped, but an open range stays open.
			num_overflow = 1'b0;
		end else if (span_open) begin
			top = (have_digits && num_value < bound_hi) ? num_value + 1'b1 : bound_hi;
			if (top > span_start) begin
				lo_val = span_start;
				hi_val = top;
				give   = 1'b1;
			end
			span_open = 1'b0;
		end else if (have_digits && num_value >= bound_lo && num_value < bound_hi) begin
			lo_val = num_value;
			hi_val = num_value + 1'b1;
			give   = 1'b1;
		end
		have_digits = 1'b0;
		num_value   = '0;
		return give;
	endfunction

	task automatic parse_char(input in_item_t it);
		out_item_t          res;
		logic [VALUE_W-1:0] lo_val;
		logic [VALUE_W-1:0] hi_val;
		logic [35:0]        sum;
		bit                 give;
		res = '0;
		if (it.end_marker) begin
			give = 1'b0;
			if (!bad_char) begin
				give = finish_piece(lo_val, hi_val);
			end
			res.sequence_done = 1'b1;
			res.parse_failed  = bad_char;
			if (give) begin
				res.has_range   = 1'b1;
				res.range_first = lo_val;
				res.range_end   = hi_val;
			end
			expected_ranges.push_back(res);
			reset_parse();
		end else if (!bad_char) begin
			case (char_kind(it.character))
				CLS_DELIM: begin
					if (finish_piece(lo_val, hi_val)) begin
						res.has_range   = 1'b1;
						res.range_first = lo_val;
						res.range_end   = hi_val;
						expected_ranges.push_back(res);
					end
				end
				CLS_DIGIT: begin
					sum = 36'(num_value) * 36'd10 + 36'(it.character - CHAR_ZERO);
					have_digits = 1'b1;
					if (sum > 36'hFFFF_FFFF) begin
						num_overflow = 1'b1;
					end
					num_value = sum[VALUE_W-1:0];
				end
				CLS_DASH: begin
					span_start  = (have_digits && num_value >= bound_lo) ? num_value : bound_lo;
					span_open   = 1'b1;
					have_digits = 1'b0;
					num_value   = '0;
				end
				default: begin
					bad_char = 1'b1;
				end
			endcase
		end
	endtask

	// Sender: offers the oldest pending character and predicts it once accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				parse_char(in_item);
				void'(text_queue.pop_front());
			end
			if (in_valid && in_stall) begin
				in_valid <= 1'b1;
			end else if (text_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_item  <= text_queue[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Receiver: checks each result transaction and decides its own stalls.
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_ranges.size() == 0) begin
					$display("%0t: result with none expected, actual %h %h %b %b %b", $time,
						out_item.range_first, out_item.range_end, out_item.has_range,
						out_item.sequence_done, out_item.parse_failed);
					mismatches++;
				end else begin
					want = expected_ranges.pop_front();
					check_field("range_first", want.range_first, out_item.range_first);
					check_field("range_end", want.range_end, out_item.range_end);
					check_field("has_range", want.has_range, out_item.has_range);
					check_field("sequence_done", want.sequence_done, out_item.sequence_done);
					check_field("parse_failed", want.parse_failed, out_item.parse_failed);
				end
				results_seen++;
			end
			// One long hold-off lets the output buffer fill so that the input stalls.
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	task automatic push_char(input logic [7:0] c);
		in_item_t it;
		it.character  = c;
		it.end_marker = 1'b0;
		text_queue.push_back(it);
		if (!text_broken) begin
			items_made++;
		end
	endtask

	task automatic push_end(input logic [7:0] c);
		in_item_t it;
		it.character  = c;
		it.end_marker = 1'b1;
		text_queue.push_back(it);
		items_made++;
		text_broken = 1'b0;
	endtask

	task automatic push_number(input longint unsigned v);
		logic [7:0] digits[$];
		do begin
			digits.push_front(CHAR_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digits[i]) begin
			push_char(digits[i]);
		end
	endtask

	task automatic push_operand(input longint unsigned v);
		if ($urandom_range(0, 9) == 0) begin
			push_char(CHAR_ZERO);
		end
		push_number(v);
	endtask

	// Numbers cluster around zero, the bounds, all ones and just past 32 bits.
	function automatic longint unsigned pick_value();
		longint      v;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			v = $urandom_range(0, 20);
		end else if (r < 50) begin
			v = longint'(bound_lo) + $urandom_range(0, 4) - 2;
		end else if (r < 70) begin
			v = longint'(bound_hi) + $urandom_range(0, 4) - 2;
		end else if (r < 80) begin
			v = longint'($urandom);
		end else if (r < 88) begin
			v = 64'hFFFF_FFFF;
		end else if (r < 96) begin
			v = 64'h1_0000_0000 + $urandom_range(0, 1000);
		end else begin
			v = {$urandom, $urandom} >> 1;
		end
		if (v < 0) begin
			v = 0;
		end
		return v;
	endfunction

	function automatic logic [7:0] pick_delim();
		logic [7:0] c;
		case ($urandom_range(0, 7))
			0: c = CHAR_COMMA;
			1: c = CHAR_SEMICOLON;
			2: c = CHAR_SPACE;
			3: c = CHAR_TAB;
			4: c = CHAR_LF;
			5: c = CHAR_VT;
			6: c = CHAR_FF;
			default: c = CHAR_CR;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] pick_junk();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (char_kind(c) != CLS_OTHER);
		return c;
	endfunction

	// One text: a few pieces with delimiters, now and then broken, closed by the end marker.
	task automatic make_text();
		int              pieces;
		int              kind;
		longint unsigned a;
		longint unsigned b;
		pieces = $urandom_range(0, 5);
		for (int p = 0; p < pieces; p++) begin
			kind = $urandom_range(0, 99);
			a = pick_value();
			b = ($urandom_range(0, 9) < 6) ? a + $urandom_range(0, 40) : pick_value();
			if (kind < 40) begin
				push_operand(a);
			end else if (kind < 65) begin
				push_operand(a);
				push_char(CHAR_DASH);
				push_operand(b);
			end else if (kind < 75) begin
				push_char(CHAR_DASH);
				push_operand(b);
			end else if (kind < 85) begin
				push_operand(a);
				push_char(CHAR_DASH);
			end else if (kind < 90) begin
				push_char(CHAR_DASH);
			end
			if ($urandom_range(0, 99) < 3) begin
				push_char(CHAR_DASH);
			end
			if ($urandom_range(0, 99) < 2) begin
				push_char(pick_junk());
				text_broken = 1'b1;
			end
			if (p < pieces - 1 || $urandom_range(0, 1) == 1) begin
				repeat ($urandom_range(1, 2)) push_char(pick_delim());
			end
		end
		push_end(8'($urandom_range(0, 255)));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LOWER_BOUND: bound_lo = val;
			REG_UPPER_BOUND: bound_hi = val;
			default: ;
		endcase
	endtask

	// Waits until every character is in and every result is out, then lets the pipe settle.
	task automatic wait_idle();
		while (text_queue.size() != 0 || expected_ranges.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(input int s_pct, input int r_pct, input logic [VALUE_W-1:0] lo,
			input logic [VALUE_W-1:0] hi, input int n_items);
		write_reg(REG_LOWER_BOUND, lo);
		write_reg(REG_UPPER_BOUND, hi);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		items_made = 0;
		while (items_made < n_items) begin
			make_text();
		end
		wait_idle();
	endtask

	initial begin : stimulus
		logic [VALUE_W-1:0] lo;
		reset_parse();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// "0,9-<tab>-9;<cr>": a single value, an open-ended range, an open-start range.
		push_char(CHAR_ZERO);
		push_char(CHAR_COMMA);
		push_char(CHAR_NINE);
		push_char(CHAR_DASH);
		push_char(CHAR_TAB);
		push_char(CHAR_DASH);
		push_char(CHAR_NINE);
		push_char(CHAR_SEMICOLON);
		push_char(CHAR_CR);
		push_end(8'hFF);
		// Overflow by a zero digit after all ones, then a dash that keeps the overflow pending.
		push_number(64'd42949672950);
		push_char(CHAR_DASH);
		push_end(8'h00);
		// An unknown character poisons the whole text.
		push_char(8'hFF);
		push_char(CHAR_NINE);
		push_end(CHAR_COMMA);
		wait_idle();

		run_phase(6, 45, 32'd0, 32'hFFFF_FFFF, 250);
		run_phase(6, 45, 32'd10, 32'd1000, 200);
		run_phase(45, 6, 32'd0, 32'd0, 120);
		run_phase(45, 6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 100);
		run_phase(45, 6, 32'd500, 32'd100, 150);
		run_phase(0, 0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 150);
		lo = $urandom_range(0, 200);
		run_phase(0, 0, lo, lo + $urandom_range(0, 300), 200);
		// A write to an unused index must leave both bounds alone.
		write_reg(REG_SPARE, $urandom);
		run_phase(0, 0, 32'd0, 32'hFFFF_FFFF, 200);

		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/nsrp_pkg.sv
rtl/nsrp_cfg.sv
rtl/nsrp_core.sv
rtl/nsrp_obuf.sv
rtl/number_sequence_range_parser.sv
tb/sv/tb_number_sequence_range_parser.sv
